[hdl/sbl_pkg.sv]
`default_nettype none

package sbl_pkg;

   localparam int ValueWidth  = 8;
   localparam int StatusWidth = 2;
   localparam int CountWidth  = 5;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   localparam logic [StatusWidth-1:0] ST_DONE      = 2'd0;
   localparam logic [StatusWidth-1:0] ST_FULL      = 2'd1;
   localparam logic [StatusWidth-1:0] ST_NOT_FOUND = 2'd2;

   // Outcome of the shared comparator: stored value against the item's value.
   typedef struct packed {
      logic gt;
      logic eq;
   } cmp_type;

endpackage

`default_nettype wire

[hdl/sorted_byte_list.sv]
// Ordered store of up to CAPACITY unsigned bytes, duplicates allowed. An insert
// lands after every equal value already held; a delete removes the first equal
// value. Each item gives one result with status, removed value, empty flag and
// count. The values sit in a single-port-write RAM with registered read, and
// one comparator walks it a slot at a time, reading and then evaluating each
// slot, so the block takes one item at a time. An insert walks over the stored
// values larger than the new one, a rejected insert into a full store does no
// walk, and a delete scans every stored value. A result waiting on rsp_stall
// holds the block in its final state.
`default_nettype none

module sorted_byte_list #(
   parameter int CAPACITY = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire logic                               req_operation,
   input  wire logic [sbl_pkg::ValueWidth-1:0]     req_value,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      logic [sbl_pkg::StatusWidth-1:0]    rsp_status,
   output      logic [sbl_pkg::ValueWidth-1:0]     rsp_removed_value,
   output      logic                               rsp_is_empty,
   output      logic [sbl_pkg::CountWidth-1:0]     rsp_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int IW = $clog2(CAPACITY + 1);
   localparam int VW = sbl_pkg::ValueWidth;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_EV,
      S_DEL_RD,
      S_DEL_EV,
      S_DONE
   } state_type;

   state_type                      state_ff, state_in;
   logic [IW-1:0]                  count_ff, count_in;
   logic [IW-1:0]                  idx_ff, idx_in;
   logic                           found_ff, found_in;
   logic [VW-1:0]                  value_ff, value_in;
   logic [sbl_pkg::StatusWidth-1:0] status_ff, status_in;
   logic [VW-1:0]                  removed_ff, removed_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [sbl_pkg::StatusWidth-1:0] rsp_status_ff, rsp_status_in;
   logic [VW-1:0]                  rsp_removed_ff, rsp_removed_in;
   logic                           rsp_empty_ff, rsp_empty_in;
   logic [sbl_pkg::CountWidth-1:0] rsp_count_ff, rsp_count_in;

   logic                           wr_en;
   logic [AW-1:0]                  wr_addr;
   logic [VW-1:0]                  wr_data;
   logic [AW-1:0]                  rd_addr;
   logic [VW-1:0]                  rd_data;
   sbl_pkg::cmp_type               cmp;

   logic [IW-1:0]                  idx_m1;
   logic [31:0]                    count_ext;

   sbl_ram #(
      .WIDTH(VW),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   sbl_cmp u_cmp (
      .stored(rd_data),
      .value (value_ff),
      .result(cmp)
   );

   assign idx_m1    = idx_ff - IW'(1);
   assign count_ext = 32'(count_ff);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      found_in       = found_ff;
      value_in       = value_ff;
      status_in      = status_ff;
      removed_in     = removed_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_count_in   = rsp_count_ff;
      wr_en          = 1'b0;
      wr_addr        = '0;
      wr_data        = '0;
      rd_addr        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               value_in   = req_value;
               removed_in = '0;
               idx_in     = count_ff;
               found_in   = 1'b0;
               if (req_operation == sbl_pkg::OP_INSERT) begin
                  if (count_ff == IW'(CAPACITY)) begin
                     status_in = sbl_pkg::ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_INS_RD;
                  end
               end else begin
                  idx_in   = '0;
                  state_in = S_DEL_RD;
               end
            end
         end
         // Insert walks down from the top, moving each larger value up a slot.
         S_INS_RD: begin
            if (idx_ff == '0) begin
               wr_en     = 1'b1;
               wr_addr   = '0;
               wr_data   = value_ff;
               count_in  = count_ff + IW'(1);
               status_in = sbl_pkg::ST_DONE;
               state_in  = S_DONE;
            end else begin
               rd_addr  = idx_m1[AW-1:0];
               state_in = S_INS_EV;
            end
         end
         S_INS_EV: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            if (cmp.gt) begin
               wr_data  = rd_data;
               idx_in   = idx_m1;
               state_in = S_INS_RD;
            end else begin
               wr_data   = value_ff;
               count_in  = count_ff + IW'(1);
               status_in = sbl_pkg::ST_DONE;
               state_in  = S_DONE;
            end
         end
         // Delete scans every stored value; once the match is seen, each later
         // value moves down one slot.
         S_DEL_RD: begin
            if (idx_ff == count_ff) begin
               if (found_ff) begin
                  count_in   = count_ff - IW'(1);
                  status_in  = sbl_pkg::ST_DONE;
                  removed_in = value_ff;
               end else begin
                  status_in = sbl_pkg::ST_NOT_FOUND;
               end
               state_in = S_DONE;
            end else begin
               rd_addr  = idx_ff[AW-1:0];
               state_in = S_DEL_EV;
            end
         end
         S_DEL_EV: begin
            if (found_ff) begin
               wr_en   = 1'b1;
               wr_addr = idx_m1[AW-1:0];
               wr_data = rd_data;
            end else if (cmp.eq) begin
               found_in = 1'b1;
            end
            idx_in   = idx_ff + IW'(1);
            state_in = S_DEL_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_removed_in = removed_ff;
               rsp_empty_in   = (count_ff == '0);
               rsp_count_in   = count_ext[sbl_pkg::CountWidth-1:0];
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff         <= idx_in;
      found_ff       <= found_in;
      value_ff       <= value_in;
      status_ff      <= status_in;
      removed_ff     <= removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_is_empty      = rsp_empty_ff;
   assign rsp_count         = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= IW'(CAPACITY))
      else $error("stored count above capacity");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && status_ff == sbl_pkg::ST_FULL) |-> count_ff == IW'(CAPACITY))
      else $error("full status while store has room");

   a_not_found_removed_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == sbl_pkg::ST_NOT_FOUND) |-> rsp_removed_value == '0)
      else $error("removed value set on a failed delete");

   a_delete_decrements: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEL_RD && idx_ff == count_ff && found_ff)
      |=> count_ff == $past(count_ff) - IW'(1))
      else $error("successful delete did not lower the count");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEL_EV || state_ff == S_INS_EV) |-> idx_ff <= count_ff)
      else $error("scan index beyond stored values");

endmodule

`default_nettype wire

[hdl/sbl_ram.sv]
`default_nettype none

module sbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[hdl/sbl_cmp.sv]
`default_nettype none

module sbl_cmp (
   input  wire logic [sbl_pkg::ValueWidth-1:0] stored,
   input  wire logic [sbl_pkg::ValueWidth-1:0] value,
   output      sbl_pkg::cmp_type               result
);

   // Both operands are unsigned bytes.
   assign result.gt = (stored > value);
   assign result.eq = (stored == value);

endmodule

`default_nettype wire
